[rtl/core/sphere_quad_tessellator_unit_defines.svh]
// ---------------------------------------------------------------------------
// Sphere quad tessellator assertion macros
// Shared property forms for the concurrent checks of the tessellator.
// ---------------------------------------------------------------------------
`ifndef SPHERE_QUAD_TESSELLATOR_UNIT_DEFINES_SVH
`define SPHERE_QUAD_TESSELLATOR_UNIT_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define SQT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Delayed form: the consequent must hold at a later edge than the antecedent.
`define SQT_ASSERT_LATER(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

[rtl/core/sqt_pkg.sv]
// ---------------------------------------------------------------------------
// Sphere quad tessellator package
// Shared widths, constants, register codes, records and helper functions.
// ---------------------------------------------------------------------------
package sqt_pkg;

  // Geometry limits and field widths.
  localparam int MAX_DIVISIONS = 1024;
  localparam int CNT_W         = 11;
  localparam int IDX_W         = 10;
  localparam int RAD_W         = 16;
  localparam int POS_W         = 18;
  localparam int NRM_W         = 16;
  localparam int PH_W          = 32;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS = 2'd0,
    REG_SLICES = 2'd1,
    REG_STACKS = 2'd2
  } cfg_reg_e;

  // Reciprocal of a count: ceil(2^RECIP_FRAC / count), exact for phase use.
  localparam int RECIP_FRAC  = 52;
  localparam int RECIP_W     = RECIP_FRAC + 1;
  localparam int RECIP_CNT_W = $clog2(RECIP_FRAC + 1);
  localparam int PROD_W      = CNT_W + RECIP_W;
  localparam int TH_SHIFT    = RECIP_FRAC - PH_W;
  localparam int RHO_SHIFT   = TH_SHIFT + 1;

  // CORDIC datapath.
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);
  localparam int CORDIC_W     = 34;
  localparam int TRIG_W       = 32;
  localparam int LANES        = 4;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CORDIC_W-1:0] ONE_Q30     = 34'sd1073741824;

  // Phase queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Four angles of one cell, as 32 bit phases (2^32 is a full turn).
  typedef struct packed {
    logic [PH_W-1:0] rho0;
    logic [PH_W-1:0] rho1;
    logic [PH_W-1:0] th0;
    logic [PH_W-1:0] th1;
  } phases_t;

  // Sine and cosine of the four angles, Q30.
  typedef struct packed {
    logic signed [TRIG_W-1:0] sr0;
    logic signed [TRIG_W-1:0] cr0;
    logic signed [TRIG_W-1:0] sr1;
    logic signed [TRIG_W-1:0] cr1;
    logic signed [TRIG_W-1:0] st0;
    logic signed [TRIG_W-1:0] ct0;
    logic signed [TRIG_W-1:0] st1;
    logic signed [TRIG_W-1:0] ct1;
  } trig_t;

  // Arctangent of 2^-i as a phase.
  function automatic logic [PH_W-1:0] atan_phase(input logic [4:0] i);
    logic [PH_W-1:0] r;
    case (i)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

  // A count of zero acts as one; a count above the limit acts as the limit.
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (c == '0) begin
      r = CNT_W'(1);
    end else if (c > CNT_W'(MAX_DIVISIONS)) begin
      r = CNT_W'(MAX_DIVISIONS);
    end else begin
      r = c;
    end
    return r;
  endfunction

  // Round a Q60 product half up to Q30.
  function automatic logic signed [TRIG_W-1:0] rnd30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd536870912;
    return TRIG_W'(t >>> 30);
  endfunction

endpackage

[rtl/core/sqt_recip.sv]
// ---------------------------------------------------------------------------
// Count reciprocal unit
// Restoring divider, one quotient bit a cycle, giving ceil(2^52 / count).
// ---------------------------------------------------------------------------
module sqt_recip (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [sqt_pkg::CNT_W-1:0]     divisor_i,
  output logic                          busy_o,
  output logic [sqt_pkg::RECIP_W-1:0]   recip_o
);

  logic                                 busy_q;
  logic [sqt_pkg::RECIP_CNT_W-1:0]      cnt_q;
  logic [sqt_pkg::CNT_W-2:0]            rem_q, rem_d;
  logic [sqt_pkg::RECIP_FRAC-1:0]       quo_q, quo_d;
  logic [sqt_pkg::CNT_W-1:0]            div_q;
  logic [sqt_pkg::RECIP_W-1:0]          recip_q;
  logic [sqt_pkg::CNT_W-1:0]            trial;
  logic [sqt_pkg::CNT_W-1:0]            diff;
  logic                                 fits;

  // One step of floor((2^52 - 1) / count): the dividend is all ones.
  always_comb begin
    trial = {rem_q, 1'b1};
    fits  = (trial >= div_q);
    diff  = trial - div_q;
    rem_d = fits ? diff[sqt_pkg::CNT_W-2:0] : trial[sqt_pkg::CNT_W-2:0];
    quo_d = {quo_q[sqt_pkg::RECIP_FRAC-2:0], fits};
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= sqt_pkg::RECIP_CNT_W'(sqt_pkg::RECIP_FRAC);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == sqt_pkg::RECIP_CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Remainder, quotient and the rounded-up result.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      if (cnt_q == sqt_pkg::RECIP_CNT_W'(1)) begin
        recip_q <= {1'b0, quo_d} + sqt_pkg::RECIP_W'(1);
      end
    end
  end

  assign busy_o  = busy_q;
  assign recip_o = recip_q;

endmodule

[rtl/core/sqt_front.sv]
// ---------------------------------------------------------------------------
// Tessellator front end
// Holds the registers, clamps cell indices and turns them into four phases.
// ---------------------------------------------------------------------------
module sqt_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sqt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sqt_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [sqt_pkg::IDX_W-1:0]       stack_index_i,
  input  logic [sqt_pkg::IDX_W-1:0]       slice_index_i,
  output logic [sqt_pkg::RAD_W-1:0]       radius_o,
  output logic                            ph_valid_o,
  input  logic                            ph_ready_i,
  output sqt_pkg::phases_t                ph_o
);

  logic [sqt_pkg::RAD_W-1:0]   radius_q;
  logic [sqt_pkg::CNT_W-1:0]   slices_q, stacks_q;
  logic                        start_q;
  logic                        busy_stk, busy_slc, busy;
  logic [sqt_pkg::RECIP_W-1:0] recip_stk, recip_slc;

  logic                        s1_valid_q, s2_valid_q;
  logic [sqt_pkg::IDX_W-1:0]   si_q, sj_q;
  logic                        seam_q;
  sqt_pkg::phases_t            ph_q, ph_d;

  logic [sqt_pkg::CNT_W-1:0]   stk_eff, slc_eff, stk_max, slc_max;
  logic [sqt_pkg::IDX_W-1:0]   si_clamp, sj_clamp;
  logic                        seam;
  logic                        s2_free, s1_move, accept;
  logic [sqt_pkg::CNT_W-1:0]   n_rho0, n_rho1, n_th0, n_th1;
  logic [sqt_pkg::PROD_W-1:0]  p_rho0, p_rho1, p_th0, p_th1;

  // Configuration registers; a count write restarts the reciprocal units.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= sqt_pkg::RAD_W'(256);
      slices_q <= sqt_pkg::CNT_W'(16);
      stacks_q <= sqt_pkg::CNT_W'(16);
      start_q  <= 1'b1;
    end else begin
      start_q <= cfg_we_i && ((cfg_idx_i == sqt_pkg::REG_SLICES) ||
                              (cfg_idx_i == sqt_pkg::REG_STACKS));
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          sqt_pkg::REG_RADIUS: begin
            radius_q <= cfg_data_i[sqt_pkg::RAD_W-1:0];
          end
          sqt_pkg::REG_SLICES: begin
            slices_q <= cfg_data_i[sqt_pkg::CNT_W-1:0];
          end
          sqt_pkg::REG_STACKS: begin
            stacks_q <= cfg_data_i[sqt_pkg::CNT_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign stk_eff = sqt_pkg::eff_count(stacks_q);
  assign slc_eff = sqt_pkg::eff_count(slices_q);

  sqt_recip u_recip_stk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_q),
    .divisor_i (stk_eff),
    .busy_o    (busy_stk),
    .recip_o   (recip_stk)
  );

  sqt_recip u_recip_slc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_q),
    .divisor_i (slc_eff),
    .busy_o    (busy_slc),
    .recip_o   (recip_slc)
  );

  assign busy = start_q | busy_stk | busy_slc;

  // Index clamping and seam detection on the incoming beat.
  always_comb begin
    stk_max  = stk_eff - sqt_pkg::CNT_W'(1);
    slc_max  = slc_eff - sqt_pkg::CNT_W'(1);
    si_clamp = ({1'b0, stack_index_i} > stk_max) ? stk_max[sqt_pkg::IDX_W-1:0]
                                                  : stack_index_i;
    sj_clamp = ({1'b0, slice_index_i} > slc_max) ? slc_max[sqt_pkg::IDX_W-1:0]
                                                  : slice_index_i;
    seam     = ({1'b0, sj_clamp} + sqt_pkg::CNT_W'(1)) >= slc_eff;
  end

  // Two-stage flow: clamped indices, then phases.
  assign s2_free    = !s2_valid_q || ph_ready_i;
  assign s1_move    = s1_valid_q && s2_free;
  assign in_ready_o = !busy && (!s1_valid_q || s2_free);
  assign accept     = in_valid_i && in_ready_o;

  // Phase = floor(n * 2^32 / count) by the exact reciprocal; rho halves it.
  always_comb begin
    n_rho0 = {1'b0, si_q};
    n_rho1 = {1'b0, si_q} + sqt_pkg::CNT_W'(1);
    n_th0  = {1'b0, sj_q};
    n_th1  = {1'b0, sj_q} + sqt_pkg::CNT_W'(1);
    p_rho0 = sqt_pkg::PROD_W'(n_rho0) * sqt_pkg::PROD_W'(recip_stk);
    p_rho1 = sqt_pkg::PROD_W'(n_rho1) * sqt_pkg::PROD_W'(recip_stk);
    p_th0  = sqt_pkg::PROD_W'(n_th0) * sqt_pkg::PROD_W'(recip_slc);
    p_th1  = sqt_pkg::PROD_W'(n_th1) * sqt_pkg::PROD_W'(recip_slc);
    ph_d.rho0 = p_rho0[sqt_pkg::RHO_SHIFT +: sqt_pkg::PH_W];
    ph_d.rho1 = p_rho1[sqt_pkg::RHO_SHIFT +: sqt_pkg::PH_W];
    ph_d.th0  = p_th0[sqt_pkg::TH_SHIFT +: sqt_pkg::PH_W];
    ph_d.th1  = seam_q ? '0 : p_th1[sqt_pkg::TH_SHIFT +: sqt_pkg::PH_W];
  end

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        s2_valid_q <= 1'b1;
      end else if (ph_ready_i) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      si_q   <= si_clamp;
      sj_q   <= sj_clamp;
      seam_q <= seam;
    end
    if (s1_move) begin
      ph_q <= ph_d;
    end
  end

  assign ph_valid_o = s2_valid_q;
  assign ph_o       = ph_q;
  assign radius_o   = radius_q;

endmodule

[rtl/core/sqt_queue.sv]
// ---------------------------------------------------------------------------
// Phase queue
// Short first-in first-out buffer that decouples front end and back end.
// ---------------------------------------------------------------------------
module sqt_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  sqt_pkg::phases_t  push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output sqt_pkg::phases_t  pop_data_o
);

  localparam int PTR_W = $clog2(sqt_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(sqt_pkg::QUEUE_DEPTH + 1);

  sqt_pkg::phases_t   mem_q [sqt_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(sqt_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(sqt_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(sqt_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/core/sqt_cordic.sv]
// ---------------------------------------------------------------------------
// Four-lane CORDIC
// Iterative rotation-mode CORDIC, one micro-rotation per cycle in each lane.
// ---------------------------------------------------------------------------
module sqt_cordic (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              ph_valid_i,
  output logic              ph_ready_o,
  input  sqt_pkg::phases_t  ph_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output sqt_pkg::trig_t    res_o
);

  logic signed [sqt_pkg::CORDIC_W-1:0] x_q [sqt_pkg::LANES];
  logic signed [sqt_pkg::CORDIC_W-1:0] y_q [sqt_pkg::LANES];
  logic signed [sqt_pkg::CORDIC_W-1:0] z_q [sqt_pkg::LANES];
  logic [1:0]                          quad_q [sqt_pkg::LANES];
  logic [sqt_pkg::PH_W-1:0]            lane_ph [sqt_pkg::LANES];
  logic signed [sqt_pkg::TRIG_W-1:0]   cos_l [sqt_pkg::LANES];
  logic signed [sqt_pkg::TRIG_W-1:0]   sin_l [sqt_pkg::LANES];
  logic signed [sqt_pkg::CORDIC_W-1:0] at;
  logic                                run_q, res_valid_q;
  logic [sqt_pkg::STEP_W-1:0]          cnt_q;
  sqt_pkg::trig_t                      res_q, res_d;
  logic                                load, done, res_wr;

  function automatic logic signed [sqt_pkg::TRIG_W-1:0] clamp_q30(
    input logic signed [sqt_pkg::CORDIC_W-1:0] v
  );
    logic signed [sqt_pkg::CORDIC_W-1:0] r;
    if (v > sqt_pkg::ONE_Q30) begin
      r = sqt_pkg::ONE_Q30;
    end else if (v < -sqt_pkg::ONE_Q30) begin
      r = -sqt_pkg::ONE_Q30;
    end else begin
      r = v;
    end
    return sqt_pkg::TRIG_W'(r);
  endfunction

  assign lane_ph[0] = ph_i.rho0;
  assign lane_ph[1] = ph_i.rho1;
  assign lane_ph[2] = ph_i.th0;
  assign lane_ph[3] = ph_i.th1;

  assign ph_ready_o  = !run_q;
  assign load        = ph_valid_i && ph_ready_o;
  assign done        = run_q && (cnt_q == sqt_pkg::STEP_W'(sqt_pkg::CORDIC_STEPS));
  assign res_wr      = done && (!res_valid_q || res_ready_i);
  assign at          = sqt_pkg::CORDIC_W'(sqt_pkg::atan_phase(5'(cnt_q)));
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Clamp and fold the quadrant back in.
  always_comb begin
    for (int l = 0; l < sqt_pkg::LANES; l++) begin
      case (quad_q[l])
        2'd0: begin
          cos_l[l] = clamp_q30(x_q[l]);
          sin_l[l] = clamp_q30(y_q[l]);
        end
        2'd1: begin
          cos_l[l] = -clamp_q30(y_q[l]);
          sin_l[l] = clamp_q30(x_q[l]);
        end
        2'd2: begin
          cos_l[l] = -clamp_q30(x_q[l]);
          sin_l[l] = -clamp_q30(y_q[l]);
        end
        default: begin
          cos_l[l] = clamp_q30(y_q[l]);
          sin_l[l] = -clamp_q30(x_q[l]);
        end
      endcase
    end
    res_d.sr0 = sin_l[0];
    res_d.cr0 = cos_l[0];
    res_d.sr1 = sin_l[1];
    res_d.cr1 = cos_l[1];
    res_d.st0 = sin_l[2];
    res_d.ct0 = cos_l[2];
    res_d.st1 = sin_l[3];
    res_d.ct1 = cos_l[3];
  end

  // Iteration control and result hand-off.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (load) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q && !done) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (res_wr) begin
        run_q <= 1'b0;
      end
      if (res_wr) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Lane datapath: micro-rotation toward zero residual angle.
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < sqt_pkg::LANES; l++) begin
      if (load) begin
        x_q[l]    <= sqt_pkg::CORDIC_GAIN;
        y_q[l]    <= '0;
        z_q[l]    <= sqt_pkg::CORDIC_W'({2'b00, lane_ph[l][29:0]});
        quad_q[l] <= lane_ph[l][31:30];
      end else if (run_q && !done) begin
        if (!z_q[l][sqt_pkg::CORDIC_W-1]) begin
          x_q[l] <= x_q[l] - (y_q[l] >>> cnt_q);
          y_q[l] <= y_q[l] + (x_q[l] >>> cnt_q);
          z_q[l] <= z_q[l] - at;
        end else begin
          x_q[l] <= x_q[l] + (y_q[l] >>> cnt_q);
          y_q[l] <= y_q[l] - (x_q[l] >>> cnt_q);
          z_q[l] <= z_q[l] + at;
        end
      end
    end
    if (res_wr) begin
      res_q <= res_d;
    end
  end

endmodule

[rtl/core/sqt_emit.sv]
// ---------------------------------------------------------------------------
// Vertex emitter
// Builds the four corner unit vectors, then sends six scaled vertex beats.
// ---------------------------------------------------------------------------
module sqt_emit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            trig_valid_i,
  output logic                            trig_ready_o,
  input  sqt_pkg::trig_t                  trig_i,
  input  logic [sqt_pkg::RAD_W-1:0]       radius_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [sqt_pkg::POS_W-1:0] pos_x_o,
  output logic signed [sqt_pkg::POS_W-1:0] pos_y_o,
  output logic signed [sqt_pkg::POS_W-1:0] pos_z_o,
  output logic signed [sqt_pkg::NRM_W-1:0] norm_x_o,
  output logic signed [sqt_pkg::NRM_W-1:0] norm_y_o,
  output logic signed [sqt_pkg::NRM_W-1:0] norm_z_o,
  output logic                            last_o
);

  localparam int BEATS = 6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PTS,
    ST_BEATS
  } state_e;

  state_e                             state_q;
  logic [1:0]                         pcnt_q;
  logic [2:0]                         bcnt_q;
  logic                               out_valid_q;
  logic signed [sqt_pkg::TRIG_W-1:0]  ux_q [4];
  logic signed [sqt_pkg::TRIG_W-1:0]  uy_q [4];
  logic signed [sqt_pkg::TRIG_W-1:0]  uz_q [4];

  logic signed [sqt_pkg::TRIG_W-1:0]  sr, cr, st, ct;
  logic signed [63:0]                 prod_x, prod_y;
  logic [1:0]                         vsel;
  logic signed [sqt_pkg::TRIG_W-1:0]  vx, vy, vz, nx, ny, nz;
  logic signed [63:0]                 rad, mul_x, mul_y, mul_z;
  logic                               load_beat;

  // Corner of each vertex beat: P1 P2 P3, then P2 P4 P3.
  function automatic logic [1:0] vertex_point(input logic [2:0] k);
    logic [1:0] r;
    case (k)
      3'd0:    r = 2'd0;
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd1;
      3'd4:    r = 2'd3;
      default: r = 2'd2;
    endcase
    return r;
  endfunction

  // Unit component to Q1.15 with rounding and saturation.
  function automatic logic signed [sqt_pkg::NRM_W-1:0] to_norm(
    input logic signed [sqt_pkg::TRIG_W-1:0] v
  );
    logic signed [sqt_pkg::TRIG_W-1:0] t;
    logic signed [sqt_pkg::TRIG_W-1:0] r;
    t = (v + 32'sd16384) >>> 15;
    if (t > 32'sd32767) begin
      r = 32'sd32767;
    end else if (t < -32'sd32768) begin
      r = -32'sd32768;
    end else begin
      r = t;
    end
    return sqt_pkg::NRM_W'(r);
  endfunction

  // Corner point: bit 0 picks the lower stack, bit 1 the next slice.
  always_comb begin
    sr     = pcnt_q[0] ? trig_i.sr1 : trig_i.sr0;
    cr     = pcnt_q[0] ? trig_i.cr1 : trig_i.cr0;
    st     = pcnt_q[1] ? trig_i.st1 : trig_i.st0;
    ct     = pcnt_q[1] ? trig_i.ct1 : trig_i.ct0;
    prod_x = 64'(st) * 64'(sr);
    prod_y = 64'(ct) * 64'(sr);
  end

  // Beat datapath: scale the corner by the radius.
  always_comb begin
    vsel  = vertex_point(bcnt_q);
    vx    = ux_q[vsel];
    vy    = uy_q[vsel];
    vz    = uz_q[vsel];
    rad   = 64'($signed({1'b0, radius_i}));
    mul_x = 64'(vx) * rad;
    mul_y = 64'(vy) * rad;
    mul_z = 64'(vz) * rad;
    nx    = (bcnt_q < 3'd3) ? ux_q[0] : ux_q[1];
    ny    = (bcnt_q < 3'd3) ? uy_q[0] : uy_q[1];
    nz    = (bcnt_q < 3'd3) ? uz_q[0] : uz_q[1];
  end

  assign trig_ready_o = (state_q == ST_PTS) && (pcnt_q == 2'd3);
  assign load_beat    = (state_q == ST_BEATS) && (!out_valid_q || out_ready_i);
  assign out_valid_o  = out_valid_q;

  // Sequencer with the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pcnt_q      <= '0;
      bcnt_q      <= '0;
      out_valid_q <= 1'b0;
      pos_x_o     <= '0;
      pos_y_o     <= '0;
      pos_z_o     <= '0;
      norm_x_o    <= '0;
      norm_y_o    <= '0;
      norm_z_o    <= '0;
      last_o      <= 1'b0;
    end else begin
      if (load_beat) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (trig_valid_i) begin
            state_q <= ST_PTS;
            pcnt_q  <= '0;
          end
        end
        ST_PTS: begin
          pcnt_q <= pcnt_q + 1'b1;
          if (pcnt_q == 2'd3) begin
            state_q <= ST_BEATS;
            bcnt_q  <= '0;
          end
        end
        ST_BEATS: begin
          if (load_beat) begin
            pos_x_o     <= sqt_pkg::POS_W'(sqt_pkg::rnd30(mul_x));
            pos_y_o     <= sqt_pkg::POS_W'(sqt_pkg::rnd30(mul_y));
            pos_z_o     <= sqt_pkg::POS_W'(sqt_pkg::rnd30(mul_z));
            norm_x_o    <= to_norm(nx);
            norm_y_o    <= to_norm(ny);
            norm_z_o    <= to_norm(nz);
            last_o      <= (bcnt_q == 3'(BEATS - 1));
            bcnt_q      <= bcnt_q + 1'b1;
            if (bcnt_q == 3'(BEATS - 1)) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Corner unit vectors, one corner a cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_PTS) begin
      ux_q[pcnt_q] <= sqt_pkg::rnd30(-prod_x);
      uy_q[pcnt_q] <= sqt_pkg::rnd30(prod_y);
      uz_q[pcnt_q] <= cr;
    end
  end

endmodule

[rtl/core/sphere_quad_tessellator_unit.sv]
// ---------------------------------------------------------------------------
// Sphere quad tessellator
// Turns one UV sphere cell into its two triangles as six vertex beats.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  cfg       in         cfg_we_i               cfg_idx_i, cfg_data_i
//  in        in         in_valid_i/in_ready_o  stack_index_i, slice_index_i
//  out       out        out_valid_o/out_ready_i pos_*, norm_*, last_o
//
// A cell holds the four-lane CORDIC from its load through 16 micro-rotations
// to the hand-off of its result; no new cell is loaded before that hand-off.
// The first vertex beat follows the front stages, queue, CORDIC and corners.
// After reset, and after a write of slice_count or stack_count, the count
// reciprocals are rebuilt bit-serially and input is held off until both are done.
// The phase queue lets the front end take cells while the back end stalls.
`include "sphere_quad_tessellator_unit_defines.svh"

module sphere_quad_tessellator_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sqt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sqt_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [sqt_pkg::IDX_W-1:0]        stack_index_i,
  input  logic [sqt_pkg::IDX_W-1:0]        slice_index_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [sqt_pkg::POS_W-1:0] pos_x_o,
  output logic signed [sqt_pkg::POS_W-1:0] pos_y_o,
  output logic signed [sqt_pkg::POS_W-1:0] pos_z_o,
  output logic signed [sqt_pkg::NRM_W-1:0] norm_x_o,
  output logic signed [sqt_pkg::NRM_W-1:0] norm_y_o,
  output logic signed [sqt_pkg::NRM_W-1:0] norm_z_o,
  output logic                             last_o
);

  logic [sqt_pkg::RAD_W-1:0] radius;
  logic                      fr_valid, fr_ready;
  sqt_pkg::phases_t          fr_ph;
  logic                      q_valid, q_ready;
  sqt_pkg::phases_t          q_ph;
  logic                      trig_valid, trig_ready;
  sqt_pkg::trig_t            trig;
  logic                      count_wr;

  // Front end: registers, clamping, phases.
  sqt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .stack_index_i (stack_index_i),
    .slice_index_i (slice_index_i),
    .radius_o      (radius),
    .ph_valid_o    (fr_valid),
    .ph_ready_i    (fr_ready),
    .ph_o          (fr_ph)
  );

  // Queue between the two halves.
  sqt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_ph),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_ph)
  );

  // Back end: sine and cosine of the four angles.
  sqt_cordic u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ph_valid_i  (q_valid),
    .ph_ready_o  (q_ready),
    .ph_i        (q_ph),
    .res_valid_o (trig_valid),
    .res_ready_i (trig_ready),
    .res_o       (trig)
  );

  // Back end: corners and vertex beats.
  sqt_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .trig_valid_i (trig_valid),
    .trig_ready_o (trig_ready),
    .trig_i       (trig),
    .radius_i     (radius),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .pos_z_o      (pos_z_o),
    .norm_x_o     (norm_x_o),
    .norm_y_o     (norm_y_o),
    .norm_z_o     (norm_z_o),
    .last_o       (last_o)
  );

  // A write of either count register.
  assign count_wr = cfg_we_i && ((cfg_idx_i == sqt_pkg::REG_SLICES) ||
                                 (cfg_idx_i == sqt_pkg::REG_STACKS));

  // A count write must hold off input until the reciprocals are rebuilt.
  `SQT_ASSERT_NEXT(a_count_write_holds_input, count_wr, !in_ready_o, "input taken in rebuild")

  // Once the emitter takes a cell, a vertex beat is on the output shortly.
  `SQT_ASSERT_LATER(a_cell_reaches_output, trig_valid && trig_ready, out_valid_o, "no beat")

endmodule

[tb/sphere_quad_tessellator_unit_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Sphere quad tessellator checker
// Watches the cell and vertex channels, computes the six vertex beats of
// every accepted cell with a local CORDIC model, and compares each beat in full.
// ---------------------------------------------------------------------------
module sphere_quad_tessellator_unit_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sqt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sqt_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [sqt_pkg::IDX_W-1:0]        stack_index_i,
  input  logic [sqt_pkg::IDX_W-1:0]        slice_index_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic signed [sqt_pkg::POS_W-1:0] pos_x_i,
  input  logic signed [sqt_pkg::POS_W-1:0] pos_y_i,
  input  logic signed [sqt_pkg::POS_W-1:0] pos_z_i,
  input  logic signed [sqt_pkg::NRM_W-1:0] norm_x_i,
  input  logic signed [sqt_pkg::NRM_W-1:0] norm_y_i,
  input  logic signed [sqt_pkg::NRM_W-1:0] norm_z_i,
  input  logic                             last_i,
  output int                               fail_count_o,
  output int                               pending_o,
  output int                               vertex_count_o
);

  typedef struct packed {
    logic signed [sqt_pkg::POS_W-1:0] px;
    logic signed [sqt_pkg::POS_W-1:0] py;
    logic signed [sqt_pkg::POS_W-1:0] pz;
    logic signed [sqt_pkg::NRM_W-1:0] nx;
    logic signed [sqt_pkg::NRM_W-1:0] ny;
    logic signed [sqt_pkg::NRM_W-1:0] nz;
    logic                             lst;
  } vertex_t;

  localparam longint GAIN_Q30 = 652032874;
  localparam longint UNIT_Q30 = 1073741824;

  vertex_t     vertex_q[$];
  logic [15:0] radius_q;
  logic [10:0] slices_q;
  logic [10:0] stacks_q;

  // Arctangent of 2^-i as a phase, 2^32 a full turn.
  function automatic longint atan_ph(int i);
    case (i)
      0: return 64'h20000000;  1: return 64'h12E4051E;  2: return 64'h09FB385B;
      3: return 64'h051111D4;  4: return 64'h028B0D43;  5: return 64'h0145D7E1;
      6: return 64'h00A2F61E;  7: return 64'h00517C55;  8: return 64'h0028BE53;
      9: return 64'h00145F2F; 10: return 64'h000A2F98; 11: return 64'h000517CC;
      12: return 64'h00028BE6; 13: return 64'h000145F3; 14: return 64'h0000A2FA;
      default: return 64'h0000517D;
    endcase
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Rotation-mode CORDIC over one quadrant, then quadrant fold.
  function automatic void cordic_sincos(logic [31:0] ph, output longint s,
                                        output longint c);
    longint x, y, z, dx, dy;
    x = GAIN_Q30;
    y = 0;
    z = longint'(ph[29:0]);
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_ph(i);
      end else begin
        x += dx; y -= dy; z += atan_ph(i);
      end
    end
    x = clip(x, -UNIT_Q30, UNIT_Q30);
    y = clip(y, -UNIT_Q30, UNIT_Q30);
    case (ph[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint round_q30(longint p);
    return (p + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic void sphere_point(logic [31:0] rho, logic [31:0] th,
                                       output longint u[3]);
    longint sr, cr, st, ct;
    cordic_sincos(rho, sr, cr);
    cordic_sincos(th, st, ct);
    u[0] = round_q30(-(st * sr));
    u[1] = round_q30(ct * sr);
    u[2] = cr;
  endfunction

  function automatic longint div_count(logic [10:0] c);
    if (c == 0) return 1;
    if (c > sqt_pkg::MAX_DIVISIONS) return sqt_pkg::MAX_DIVISIONS;
    return c;
  endfunction

  // Expand one cell into its six vertex beats.
  function automatic void tessellate_cell(logic [9:0] stk, logic [9:0] slc);
    longint stacks, slices, si, sj;
    logic [31:0] rho0, rho1, th0, th1;
    longint p[4][3];
    longint u[3];
    int     corner[6] = '{0, 1, 2, 1, 3, 2};
    vertex_t v;
    longint  nv[3];
    stacks = div_count(stacks_q);
    slices = div_count(slices_q);
    si = stk;
    sj = slc;
    if (si > stacks - 1) si = stacks - 1;
    if (sj > slices - 1) sj = slices - 1;
    rho0 = 32'((si <<< 31) / stacks);
    rho1 = 32'(((si + 1) <<< 31) / stacks);
    th0  = 32'((sj <<< 32) / slices);
    th1  = (sj + 1 >= slices) ? 32'd0 : 32'(((sj + 1) <<< 32) / slices);
    sphere_point(rho0, th0, u); p[0] = u;
    sphere_point(rho1, th0, u); p[1] = u;
    sphere_point(rho0, th1, u); p[2] = u;
    sphere_point(rho1, th1, u); p[3] = u;
    for (int k = 0; k < 6; k++) begin
      for (int a = 0; a < 3; a++) begin
        nv[a] = (k < 3) ? p[0][a] : p[1][a];
      end
      v.px = sqt_pkg::POS_W'(round_q30(p[corner[k]][0] * longint'(radius_q)));
      v.py = sqt_pkg::POS_W'(round_q30(p[corner[k]][1] * longint'(radius_q)));
      v.pz = sqt_pkg::POS_W'(round_q30(p[corner[k]][2] * longint'(radius_q)));
      v.nx = sqt_pkg::NRM_W'(clip((nv[0] + 16384) >>> 15, -32768, 32767));
      v.ny = sqt_pkg::NRM_W'(clip((nv[1] + 16384) >>> 15, -32768, 32767));
      v.nz = sqt_pkg::NRM_W'(clip((nv[2] + 16384) >>> 15, -32768, 32767));
      v.lst = (k == 5);
      vertex_q = {vertex_q, v};
    end
  endfunction

  assign pending_o = vertex_q.size();

  // Register shadow, predictions and comparisons on each edge.
  always @(posedge clk_i or negedge rst_ni) begin
    vertex_t exp_v;
    vertex_t got_v;
    if (!rst_ni) begin
      radius_q       <= 16'd256;
      slices_q       <= 11'd16;
      stacks_q       <= 11'd16;
      fail_count_o   <= 0;
      vertex_count_o <= 0;
      vertex_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (sqt_pkg::cfg_reg_e'(cfg_idx_i))
          sqt_pkg::REG_RADIUS: radius_q <= cfg_data_i;
          sqt_pkg::REG_SLICES: slices_q <= cfg_data_i[10:0];
          sqt_pkg::REG_STACKS: stacks_q <= cfg_data_i[10:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        tessellate_cell(stack_index_i, slice_index_i);
      end
      if (out_valid_i && out_ready_i) begin
        got_v = '{pos_x_i, pos_y_i, pos_z_i, norm_x_i, norm_y_i, norm_z_i, last_i};
        vertex_count_o <= vertex_count_o + 1;
        if (vertex_q.size() == 0) begin
          $display("%0t: unexpected vertex beat, actual %p", $time, got_v);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_v = vertex_q.pop_front();
          if (exp_v != got_v) begin
            $display("%0t: vertex mismatch, expected %p, actual %p", $time, exp_v,
                     got_v);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

[tb/sphere_quad_tessellator_unit_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Sphere quad tessellator testbench
// Drives directed and random cells through several sphere settings with
// random gaps and a long output stall; the checker scores every vertex.
// ---------------------------------------------------------------------------
module sphere_quad_tessellator_unit_tb;

  localparam int WATCHDOG_LIMIT = 20000;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we_i = 1'b0;
  logic [sqt_pkg::CFG_IDX_W-1:0]    cfg_idx_i = '0;
  logic [sqt_pkg::CFG_DATA_W-1:0]   cfg_data_i = '0;
  logic                             in_valid_i = 1'b0;
  logic                             in_ready_o;
  logic [sqt_pkg::IDX_W-1:0]        stack_index_i = '0;
  logic [sqt_pkg::IDX_W-1:0]        slice_index_i = '0;
  logic                             out_valid_o;
  logic                             out_ready_i = 1'b0;
  logic signed [sqt_pkg::POS_W-1:0] pos_x_o, pos_y_o, pos_z_o;
  logic signed [sqt_pkg::NRM_W-1:0] norm_x_o, norm_y_o, norm_z_o;
  logic                             last_o;
  int                               fail_count, pending, vertex_count;
  int                               cell_count = 0;
  int                               idle_cycles = 0;
  bit                               stall_done = 1'b0;

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sphere_quad_tessellator_unit dut (.*);

  sphere_quad_tessellator_unit_checker checker_u (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .in_valid_i,
    .in_ready_i(in_ready_o), .stack_index_i, .slice_index_i,
    .out_valid_i(out_valid_o), .out_ready_i, .pos_x_i(pos_x_o), .pos_y_i(pos_y_o),
    .pos_z_i(pos_z_o), .norm_x_i(norm_x_o), .norm_y_i(norm_y_o),
    .norm_z_i(norm_z_o), .last_i(last_o), .fail_count_o(fail_count),
    .pending_o(pending), .vertex_count_o(vertex_count));

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver: random stalls of mixed length, one long hold-off and a stall-free stretch.
  always @(posedge clk_i) begin
    int hold;
    if (rst_ni) begin
      if (!stall_done && cell_count >= 30) begin
        stall_done = 1'b1;
        out_ready_i <= 1'b0;
        for (hold = 0; hold < 400; hold++) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (cell_count > 150 && cell_count < 220) begin
        out_ready_i <= 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog on accepted beats.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_cell(input logic [sqt_pkg::IDX_W-1:0] stk,
                           input logic [sqt_pkg::IDX_W-1:0] slc);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    stack_index_i <= stk;
    slice_index_i <= slc;
    do @(posedge clk_i); while (!in_ready_o);
    cell_count++;
  endtask

  task automatic drain_and_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(input sqt_pkg::cfg_reg_e idx,
                           input logic [sqt_pkg::CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_cells(input int n, input int span);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: send_cell(10'($urandom), 10'($urandom));
        default: send_cell(10'($urandom_range(0, span)), 10'($urandom_range(0, span)));
      endcase
    end
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed cells at reset settings: poles, seam, clamping, bit extremes.
    send_cell(10'd0, 10'd0);
    send_cell(10'd15, 10'd0);
    send_cell(10'd0, 10'd15);
    send_cell(10'd15, 10'd15);
    send_cell(10'd7, 10'd4);
    send_cell(10'd1023, 10'd1023);
    send_cell(10'h2AA, 10'h155);
    send_cell(10'h155, 10'h2AA);
    send_cell(10'd8, 10'd12);
    drain_and_idle();

    // Extreme settings: zero counts, largest radius.
    write_reg(sqt_pkg::REG_RADIUS, 16'hFFFF);
    write_reg(sqt_pkg::REG_SLICES, 16'd0);
    write_reg(sqt_pkg::REG_STACKS, 16'd0);
    send_cell(10'd0, 10'd0);
    send_cell(10'd1023, 10'd5);
    drain_and_idle();

    // Counts above the limit and the top of the field, radius zero; a write
    // to an index beyond the register list must change nothing.
    write_reg(sqt_pkg::REG_RADIUS, 16'd0);
    write_reg(sqt_pkg::REG_SLICES, 16'h07FF);
    write_reg(sqt_pkg::REG_STACKS, 16'd1025);
    write_reg(sqt_pkg::cfg_reg_e'(2'd3), 16'hFFFF);
    send_cell(10'd1023, 10'd1023);
    send_cell(10'd0, 10'd1022);
    send_cell(10'd512, 10'd256);
    drain_and_idle();

    // Full-size sphere with largest radius, random cells.
    write_reg(sqt_pkg::REG_RADIUS, 16'hFFFF);
    write_reg(sqt_pkg::REG_SLICES, 16'd1024);
    write_reg(sqt_pkg::REG_STACKS, 16'd1024);
    random_cells(100, 1023);
    drain_and_idle();

    // Small odd sphere, random radius.
    write_reg(sqt_pkg::REG_RADIUS, 16'($urandom));
    write_reg(sqt_pkg::REG_SLICES, 16'd3);
    write_reg(sqt_pkg::REG_STACKS, 16'd1);
    random_cells(100, 4);
    drain_and_idle();

    // Random mid-size sphere.
    write_reg(sqt_pkg::REG_RADIUS, 16'($urandom));
    write_reg(sqt_pkg::REG_SLICES, 16'($urandom_range(2, 64)));
    write_reg(sqt_pkg::REG_STACKS, 16'($urandom_range(2, 64)));
    random_cells(200, 70);
    drain_and_idle();

    $display("tb: %0d cells, %0d vertex beats over six sphere settings", cell_count,
             vertex_count);
    $display("tb: covered poles, seam, index clamping, count limits and long stall");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/sqt_pkg.sv
rtl/core/sqt_recip.sv
rtl/core/sqt_front.sv
rtl/core/sqt_queue.sv
rtl/core/sqt_cordic.sv
rtl/core/sqt_emit.sv
rtl/core/sphere_quad_tessellator_unit.sv
tb/sphere_quad_tessellator_unit_checker.sv
tb/sphere_quad_tessellator_unit_tb.sv
